[src/sdinit_pkg.sv]
// Package for the SD/eMMC card bring-up sequencer: payload types, phase enum,
// command constants and small decode helpers. No dependencies.
package sdinit_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam logic [9:0] RETRY_RESET = 10'd1000;
  localparam int unsigned QDEPTH = 4;

  typedef enum logic [1:0] {
    K_START = 2'd0,
    K_RESP  = 2'd1,
    K_ERR   = 2'd2,
    K_DATA  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    A_CMD  = 2'd0,
    A_BUS4 = 2'd1,
    A_DONE = 2'd2,
    A_FAIL = 2'd3
  } action_t;

  localparam logic [2:0] RT_NONE = 3'd0;
  localparam logic [2:0] RT_R1   = 3'd1;
  localparam logic [2:0] RT_R1B  = 3'd2;
  localparam logic [2:0] RT_R2   = 3'd3;
  localparam logic [2:0] RT_R3   = 3'd4;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [31:0] ARG_VOLT    = 32'h00FF_8000;
  localparam logic [31:0] ARG_MMC_OCR = 32'h40FF_8080;
  localparam logic [31:0] OCR_READY   = 32'h8000_0000;
  localparam logic [31:0] ARG_MMC_BUS = 32'h03B7_0100;

  typedef enum logic [4:0] {
    PH_IDLE, PH_CMD0, PH_CMD8, PH_APP55, PH_ACMD41, PH_MMC0, PH_CMD1,
    PH_CMD2, PH_CMD3, PH_CMD9, PH_CMD7, PH_EXTCMD, PH_EXTDATA,
    PH_BUSMMC, PH_BUSAPP, PH_BUSACMD6, PH_CMD16, PH_DONE, PH_FAILED
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic [6:0]  word_index;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [2:0]  response_type;
    logic        data_read;
    logic        is_mmc;
    logic        block_addressed;
    logic [15:0] card_address;
    logic [32:0] sector_count;
    logic        last_result;
  } out_item_t;

  // Classified event handed from front to back.
  typedef struct packed {
    logic        start;
    logic        err;
    logic        resp;
    logic        data;
    logic        last;
    logic        ocr_ready;
    logic        ocr_hcs;
    logic        chk_aa;
    logic        idx_csd;
    logic        idx_ext;
    logic [1:0]  csd_sel;
    logic [31:0] word;
  } event_t;

  function automatic logic [31:0] csd_field(input logic [127:0] csd,
                                            input int unsigned start,
                                            input int unsigned len);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < len) v[i] = csd[start - 8 + i];
    end
    return v;
  endfunction

endpackage

[src/sdinit_front.sv]
// Front end: accepts input items, classifies them and queues events.
// Depends on sdinit_pkg.
module sdinit_front import sdinit_pkg::*; #(
  parameter int unsigned DEPTH = QDEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     ev_valid,
  input  logic     ev_take,
  output event_t   ev
);
  localparam int unsigned AW = $clog2(DEPTH);

  event_t         q [DEPTH];
  logic [AW-1:0]  wr;
  logic [AW-1:0]  rd;
  logic [AW:0]    count;
  event_t         cls;
  logic           push;
  logic           pop;

  always_comb begin
    cls.start     = in_item.kind == K_START;
    cls.err       = in_item.kind == K_ERR;
    cls.resp      = in_item.kind == K_RESP;
    cls.data      = in_item.kind == K_DATA;
    cls.last      = in_item.last;
    cls.ocr_ready = (in_item.word & OCR_READY) != '0;
    cls.ocr_hcs   = in_item.word[30];
    cls.chk_aa    = in_item.word[7:0] == 8'hAA;
    cls.idx_csd   = in_item.word_index < 7'd4;
    cls.idx_ext   = in_item.word_index == 7'd53;
    cls.csd_sel   = in_item.word_index[1:0];
    cls.word      = in_item.word;
  end

  assign in_stall = count == (AW+1)'(DEPTH);
  assign push     = in_valid && !in_stall;
  assign ev_valid = count != '0;
  assign pop      = ev_valid && ev_take;
  assign ev       = q[rd];

  always_ff @(posedge clk) begin
    if (push) q[wr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop) rd <= rd + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

[src/sdinit_back.sv]
// Back end: phase machine that executes queued events and emits results
// through a two-entry output buffer. Depends on sdinit_pkg.
module sdinit_back import sdinit_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic [9:0] retry_limit,
  input  logic      ev_valid,
  output logic      ev_take,
  input  event_t    ev,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  phase_t       phase, phase_next;
  logic [9:0]   attempt, attempt_next;
  logic         sd_v2, sd_v2_next;
  logic         mmc, mmc_next;
  logic         sector, sector_next;
  logic [15:0]  rca, rca_next;
  logic [32:0]  cap, cap_next;
  logic [31:0]  csd [4];
  logic [31:0]  csd_cur [4];
  logic [127:0] csd_flat;

  out_item_t    buf0, buf1;
  logic [1:0]   bcnt;
  out_item_t    r0, r1;
  logic [1:0]   n;
  logic         csd_wr;
  logic         do_decode;
  logic [32:0]  dec_cap;
  logic         pop;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      csd_cur[i] = (ev.idx_csd && ev.csd_sel == 2'(i)) ? ev.word : csd[i];
    end
  end

  assign csd_flat = {csd_cur[3], csd_cur[2], csd_cur[1], csd_cur[0]};

  // CSD capacity decode
  always_comb begin
    logic [11:0] c_size;
    logic [2:0]  mult;
    logic [3:0]  bl_len;
    logic [32:0] s;
    s = '0;
    c_size = 12'(csd_field(csd_flat, 62, 12));
    mult   = 3'(csd_field(csd_flat, 47, 3));
    bl_len = 4'(csd_field(csd_flat, 80, 4));
    if (!mmc && 2'(csd_field(csd_flat, 126, 2)) == 2'd1) begin
      dec_cap = {1'b0, 10'd0, 22'(csd_field(csd_flat, 48, 22))} + 33'd1;
      dec_cap = dec_cap << 10;
    end else begin
      s = (33'({1'b0, c_size}) + 33'd1) << (6'(mult) + 6'd2);
      if (bl_len > 4'd9) s = s << (bl_len - 4'd9);
      dec_cap = (mmc && c_size == 12'hFFF) ? '0 : s;
    end
  end

  function automatic out_item_t mk(input action_t a, input logic [5:0] idx,
                                   input logic [31:0] arg, input logic [2:0] rt,
                                   input logic dr);
    out_item_t r;
    r = '0;
    r.action = a;
    r.cmd_index = idx;
    r.cmd_arg = arg;
    r.response_type = rt;
    r.data_read = dr;
    return r;
  endfunction

  assign pop = ev_valid && (bcnt == 2'd0 || (bcnt == 2'd1 && !out_stall));
  assign ev_take = pop;

  always_comb begin
    phase_next = phase;
    attempt_next = attempt;
    sd_v2_next = sd_v2;
    mmc_next = mmc;
    sector_next = sector;
    rca_next = rca;
    cap_next = cap;
    r0 = '0;
    r1 = '0;
    n = 2'd0;
    csd_wr = 1'b0;
    do_decode = 1'b0;
    if (ev.start) begin
      attempt_next = '0;
      sd_v2_next = 1'b0;
      mmc_next = 1'b0;
      sector_next = 1'b0;
      rca_next = '0;
      cap_next = '0;
      phase_next = PH_CMD0;
      r0 = mk(A_CMD, 6'd0, '0, RT_NONE, 1'b0);
      n = 2'd1;
    end else begin
      unique case (phase)
        PH_CMD0: begin
          if (ev.err) begin
            phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.resp && ev.last) begin
            phase_next = PH_CMD8; r0 = mk(A_CMD, 6'd8, ARG_IF_COND, RT_R1, 1'b0); n = 2'd1;
          end
        end
        PH_CMD8: begin
          if (ev.err || (ev.resp && ev.last)) begin
            sd_v2_next = ev.resp && ev.chk_aa;
            attempt_next = '0;
            n = 2'd1;
            if (retry_limit == '0) begin
              mmc_next = 1'b1; phase_next = PH_MMC0;
              r0 = mk(A_CMD, 6'd0, '0, RT_NONE, 1'b0);
            end else begin
              phase_next = PH_APP55; r0 = mk(A_CMD, 6'd55, '0, RT_R1, 1'b0);
            end
          end
        end
        PH_APP55: begin
          if (ev.err) begin
            mmc_next = 1'b1; phase_next = PH_MMC0;
            r0 = mk(A_CMD, 6'd0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.resp && ev.last) begin
            phase_next = PH_ACMD41;
            r0 = mk(A_CMD, 6'd41, (sd_v2 ? ARG_HCS : '0) | ARG_VOLT, RT_R3, 1'b0);
            n = 2'd1;
          end
        end
        PH_ACMD41, PH_CMD1: begin
          if (ev.err) begin
            n = 2'd1;
            if (phase == PH_ACMD41) begin
              mmc_next = 1'b1; phase_next = PH_MMC0;
              r0 = mk(A_CMD, 6'd0, '0, RT_NONE, 1'b0);
            end else begin
              phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0);
            end
          end else if (ev.resp && ev.last) begin
            n = 2'd1;
            if (ev.ocr_ready) begin
              sector_next = ev.ocr_hcs; phase_next = PH_CMD2;
              r0 = mk(A_CMD, 6'd2, '0, RT_R2, 1'b0);
            end else begin
              attempt_next = attempt + 10'd1;
              if (attempt_next >= retry_limit) begin
                if (phase == PH_ACMD41) begin
                  mmc_next = 1'b1; phase_next = PH_MMC0;
                  r0 = mk(A_CMD, 6'd0, '0, RT_NONE, 1'b0);
                end else begin
                  phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0);
                end
              end else if (phase == PH_ACMD41) begin
                phase_next = PH_APP55; r0 = mk(A_CMD, 6'd55, '0, RT_R1, 1'b0);
              end else begin
                phase_next = PH_CMD1; r0 = mk(A_CMD, 6'd1, ARG_MMC_OCR, RT_R3, 1'b0);
              end
            end
          end
        end
        PH_MMC0: begin
          if (ev.err) begin
            phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.resp && ev.last) begin
            attempt_next = '0; n = 2'd1;
            if (retry_limit == '0) begin
              phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0);
            end else begin
              phase_next = PH_CMD1; r0 = mk(A_CMD, 6'd1, ARG_MMC_OCR, RT_R3, 1'b0);
            end
          end
        end
        PH_CMD2: begin
          if (ev.err) begin
            phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.resp && ev.last) begin
            if (mmc) rca_next = 16'd1;
            phase_next = PH_CMD3;
            r0 = mk(A_CMD, 6'd3, mmc ? 32'h0001_0000 : '0, RT_R1, 1'b0); n = 2'd1;
          end
        end
        PH_CMD3: begin
          if (ev.err) begin
            phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.resp && ev.last) begin
            if (!mmc) rca_next = ev.word[31:16];
            phase_next = PH_CMD9;
            r0 = mk(A_CMD, 6'd9, {rca_next, 16'd0}, RT_R2, 1'b0); n = 2'd1;
          end
        end
        PH_CMD9: begin
          if (ev.err) begin
            phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.resp) begin
            csd_wr = ev.idx_csd;
            if (ev.last) begin
              do_decode = 1'b1;
              phase_next = PH_CMD7;
              r0 = mk(A_CMD, 6'd7, {rca, 16'd0}, RT_R1B, 1'b0); n = 2'd1;
            end
          end
        end
        PH_CMD7: begin
          if (ev.err) begin
            phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.resp && ev.last) begin
            n = 2'd1;
            if (cap == '0 && mmc) begin
              phase_next = PH_EXTCMD; r0 = mk(A_CMD, 6'd8, '0, RT_R1, 1'b1);
            end else if (cap == '0) begin
              phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0);
            end else if (mmc) begin
              phase_next = PH_BUSMMC; r0 = mk(A_CMD, 6'd6, ARG_MMC_BUS, RT_R1B, 1'b0);
            end else begin
              phase_next = PH_BUSAPP; r0 = mk(A_CMD, 6'd55, {rca, 16'd0}, RT_R1, 1'b0);
            end
          end
        end
        PH_EXTCMD: begin
          if (ev.err) begin
            phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.resp && ev.last) begin
            phase_next = PH_EXTDATA;
          end
        end
        PH_EXTDATA: begin
          if (ev.err) begin
            phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end else if (ev.data) begin
            if (ev.idx_ext) cap_next = {1'b0, ev.word};
            if (ev.last) begin
              n = 2'd1;
              if (cap_next == '0) begin
                phase_next = PH_FAILED; r0 = mk(A_FAIL, '0, '0, RT_NONE, 1'b0);
              end else if (mmc) begin
                phase_next = PH_BUSMMC; r0 = mk(A_CMD, 6'd6, ARG_MMC_BUS, RT_R1B, 1'b0);
              end else begin
                phase_next = PH_BUSAPP; r0 = mk(A_CMD, 6'd55, {rca, 16'd0}, RT_R1, 1'b0);
              end
            end
          end
        end
        PH_BUSMMC, PH_BUSACMD6: begin
          if (ev.err || (ev.resp && ev.last)) begin
            if (!sector) begin
              phase_next = PH_CMD16;
              r1 = mk(A_CMD, 6'd16, 32'(BLOCK_BYTES), RT_R1, 1'b0);
            end else begin
              phase_next = PH_DONE;
              r1 = mk(A_DONE, '0, '0, RT_NONE, 1'b0);
            end
            if (ev.err) begin
              r0 = r1; n = 2'd1;
            end else begin
              r0 = mk(A_BUS4, '0, '0, RT_NONE, 1'b0); n = 2'd2;
            end
          end
        end
        PH_BUSAPP: begin
          if (ev.err) begin
            n = 2'd1;
            if (!sector) begin
              phase_next = PH_CMD16;
              r0 = mk(A_CMD, 6'd16, 32'(BLOCK_BYTES), RT_R1, 1'b0);
            end else begin
              phase_next = PH_DONE; r0 = mk(A_DONE, '0, '0, RT_NONE, 1'b0);
            end
          end else if (ev.resp && ev.last) begin
            phase_next = PH_BUSACMD6; r0 = mk(A_CMD, 6'd6, 32'd2, RT_R1, 1'b0); n = 2'd1;
          end
        end
        PH_CMD16: begin
          if (ev.err || (ev.resp && ev.last)) begin
            phase_next = PH_DONE; r0 = mk(A_DONE, '0, '0, RT_NONE, 1'b0); n = 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
    if (do_decode) cap_next = dec_cap;
    r0.is_mmc = mmc_next;  r1.is_mmc = mmc_next;
    r0.block_addressed = sector_next; r1.block_addressed = sector_next;
    r0.card_address = rca_next; r1.card_address = rca_next;
    r0.sector_count = cap_next; r1.sector_count = cap_next;
    r0.last_result = n == 2'd1;
    r1.last_result = 1'b1;
  end

  // Store CSD words; the decode takes the word arriving with last directly.
  always_ff @(posedge clk) begin
    if (pop && csd_wr) csd[ev.csd_sel] <= ev.word;
  end

  assign out_valid = bcnt != 2'd0;
  assign out_item  = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      attempt <= '0;
      sd_v2 <= 1'b0;
      mmc <= 1'b0;
      sector <= 1'b0;
      rca <= '0;
      cap <= '0;
      bcnt <= '0;
    end else begin
      if (pop) begin
        phase <= phase_next;
        attempt <= attempt_next;
        sd_v2 <= sd_v2_next;
        mmc <= mmc_next;
        sector <= sector_next;
        rca <= rca_next;
        cap <= cap_next;
        bcnt <= n;
      end else if (out_valid && !out_stall) begin
        bcnt <= bcnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= r0;
      buf1 <= r1;
    end else if (out_valid && !out_stall) begin
      buf0 <= buf1;
    end
  end
endmodule

[src/sd_emmc_card_init_sequencer_core.sv]
// Top level of the SD/eMMC card bring-up sequencer: front queue, back phase
// machine and the retry limit register. Depends on sdinit_pkg.
//
// Each input event is classified on entry and queued; the phase machine takes
// one queued event per cycle whenever its output buffer is empty or its final
// result leaves in that cycle, and emits up to two result items, one per cycle
// while out_stall is low. A bus-switch completion without error is the event
// that gives two results. The queue holds DEPTH events, four by default, so
// input is taken while results wait. A CMD9 response decodes the capacity in
// the cycle its final word is taken, using that word directly.
module sd_emmc_card_init_sequencer_core import sdinit_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int unsigned DEPTH = QDEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [9:0] cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  logic [9:0] retry_limit;
  logic       ev_valid;
  logic       ev_take;
  event_t     ev;

  always_ff @(posedge clk) begin
    if (rst) retry_limit <= RETRY_RESET;
    else if (cfg_we) retry_limit <= cfg_data;
  end

  sdinit_front #(.DEPTH(DEPTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item, .ev_valid, .ev_take, .ev
  );

  sdinit_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk, .rst, .retry_limit, .ev_valid, .ev_take, .ev,
    .out_valid, .out_stall, .out_item
  );
endmodule

[src/sdinit_checker.sv]
// Port-level checks for the card bring-up sequencer, bound to the top level.
// Depends on sdinit_pkg.
module sdinit_checker import sdinit_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_cmd_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action != A_CMD |->
      out_item.cmd_index == '0 && out_item.cmd_arg == '0 && !out_item.data_read)
    else $error("command fields set on non-command result");

  a_bus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action == A_BUS4 |-> !out_item.last_result)
    else $error("bus switch result marked last");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("activity right after reset");
endmodule

bind sd_emmc_card_init_sequencer_core sdinit_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .out_item
);
